/* hw/rtl/ctw_pkg.sv */
// Shared constants, types and register codes of the census transform window.
package ctw_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int HEIGHT_LIMIT = 1024;
	localparam int VERT_RADIUS  = 4;
	localparam int HORIZ_RADIUS = 3;

	localparam int WIN_ROWS = 2 * VERT_RADIUS + 1;
	localparam int WIN_COLS = 2 * HORIZ_RADIUS + 1;
	localparam int WORD_W   = WIN_ROWS * WIN_COLS;
	localparam int TDATA_W  = ((WORD_W + 7) / 8) * 8;

	localparam int PIX_W  = 8;
	localparam int SIZE_W = 11;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(HEIGHT_LIMIT);
	localparam int OFF_W  = $clog2((WIN_ROWS - 1) * WIN_COLS + 1);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	// window: [column, oldest first][row, top first][pixel]
	typedef logic [WIN_COLS-1:0][WIN_ROWS-1:0][PIX_W-1:0] win_t;

	// centre position and frame marks travelling with a window
	typedef struct packed {
		logic             emit;
		logic             last;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} ctr_info_t;

endpackage

/* hw/rtl/ctw_pack.sv */
// Census compare, border clipping and bit packing: two register stages.
module ctw_pack (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_valid,
	input  ctw_pkg::ctr_info_t          info,
	input  ctw_pkg::win_t               win,
	input  logic [ctw_pkg::SIZE_W-1:0]  width,
	input  logic [ctw_pkg::SIZE_W-1:0]  height,
	output logic                        out_valid,
	output logic [ctw_pkg::WORD_W-1:0]  out_word,
	output logic                        out_last
);

	localparam int RS_W = ctw_pkg::SIZE_W + 1;
	localparam int TC_W = $clog2(ctw_pkg::VERT_RADIUS + 1);
	localparam int LC_W = $clog2(ctw_pkg::HORIZ_RADIUS + 1);
	localparam int NC_W = $clog2(ctw_pkg::WIN_COLS + 1);

	logic [ctw_pkg::PIX_W-1:0]    centre;
	logic [ctw_pkg::WIN_ROWS-1:0] row_ok;
	logic [ctw_pkg::WIN_COLS-1:0] col_ok;
	logic [TC_W-1:0]              top_clip;
	logic [LC_W-1:0]              left_clip;
	logic [NC_W-1:0]              ncols;
	logic [ctw_pkg::WIN_ROWS-1:0][ctw_pkg::WIN_COLS-1:0] gt;
	logic [ctw_pkg::WIN_ROWS-1:0][ctw_pkg::WIN_COLS-1:0] comp;
	logic [ctw_pkg::WIN_ROWS-1:0][ctw_pkg::OFF_W-1:0]    off;

	logic                                                 v_s3;
	logic                                                 last_s3;
	logic [ctw_pkg::WIN_ROWS-1:0][ctw_pkg::WIN_COLS-1:0] comp_s3;
	logic [ctw_pkg::WIN_ROWS-1:0][ctw_pkg::OFF_W-1:0]    off_s3;
	logic [ctw_pkg::WORD_W-1:0]                           word;

	logic                        v_s4;
	logic                        last_s4;
	logic [ctw_pkg::WORD_W-1:0]  word_s4;

	// stage 2: compare against centre, clip, squeeze each row to its in-bound columns
	always_comb begin
		centre = win[ctw_pkg::HORIZ_RADIUS][ctw_pkg::VERT_RADIUS];
		top_clip = (info.row < ctw_pkg::ROW_W'(ctw_pkg::VERT_RADIUS))
			? TC_W'(ctw_pkg::VERT_RADIUS) - TC_W'(info.row) : '0;
		left_clip = (info.col < ctw_pkg::COL_W'(ctw_pkg::HORIZ_RADIUS))
			? LC_W'(ctw_pkg::HORIZ_RADIUS) - LC_W'(info.col) : '0;
		ncols = '0;
		for (int j = 0; j < ctw_pkg::WIN_COLS; j++) begin
			col_ok[j] = (RS_W'(info.col) + RS_W'(j) >= RS_W'(ctw_pkg::HORIZ_RADIUS))
				&& (RS_W'(info.col) + RS_W'(j)
					<= RS_W'(width) + RS_W'(ctw_pkg::HORIZ_RADIUS - 1));
			ncols = ncols + NC_W'(col_ok[j]);
		end
		for (int i = 0; i < ctw_pkg::WIN_ROWS; i++) begin
			row_ok[i] = (RS_W'(info.row) + RS_W'(i) >= RS_W'(ctw_pkg::VERT_RADIUS))
				&& (RS_W'(info.row) + RS_W'(i)
					<= RS_W'(height) + RS_W'(ctw_pkg::VERT_RADIUS - 1));
			for (int j = 0; j < ctw_pkg::WIN_COLS; j++) begin
				gt[i][j] = win[j][i] > centre;
			end
			comp[i] = row_ok[i] ? ((gt[i] & col_ok) >> left_clip) : '0;
			// bit offset of this row in the packed word
			off[i] = (ctw_pkg::OFF_W'(i) - ctw_pkg::OFF_W'(top_clip))
				* ctw_pkg::OFF_W'(ncols);
		end
	end

	// stage 3: place each squeezed row at its offset
	always_comb begin
		word = '0;
		for (int i = 0; i < ctw_pkg::WIN_ROWS; i++) begin
			word = word | (ctw_pkg::WORD_W'(comp_s3[i]) << off_s3[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s3 <= in_valid;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			comp_s3 <= comp;
			off_s3  <= off;
			last_s3 <= info.last;
			word_s4 <= word;
			last_s4 <= last_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_word  = word_s4;
	assign out_last  = last_s4;

endmodule

/* hw/rtl/census_transform_window.sv */
// Top level of the 9x7 census transform: counters, line store, window and output buffer.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+-----------------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: pixel[7:0]; tuser: command
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: census_word[62:0], 0; tlast: frame_last
//  cfg      | in  | cfg_valid/cfg_ready          | cfg_index: 0 width, 1 height; cfg_data
//
//  One word per clock unless stalled; a word passes stage 1, the window, ctw_pack, the buffer.
//  Rate is set by the line store: one read and one write per item at the column address.
//  Reset clears counters and valid flags and restores the 640x480 default size; the line
//  store needs no clearing pass since rows above the frame top are always clipped.
//  Output buffer holds two words; input stalls while both are held or while cfg_valid is high.
module census_transform_window (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [ctw_pkg::PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel
	input  logic                           s_axis_tuser,   // [0] command: 1 = flush tick
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [ctw_pkg::TDATA_W-1:0]    m_axis_tdata,   // [62:0] census_word, rest zero
	output logic                           m_axis_tlast,   // frame_last
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ctw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ctw_pkg::SIZE_W-1:0]     cfg_data
);

	localparam int CNT_W = $clog2(ctw_pkg::MAX_WIDTH * ctw_pkg::HEIGHT_LIMIT
		+ ctw_pkg::VERT_RADIUS * ctw_pkg::MAX_WIDTH + ctw_pkg::HORIZ_RADIUS);
	localparam int LAG_W = $clog2(ctw_pkg::VERT_RADIUS * ctw_pkg::MAX_WIDTH
		+ ctw_pkg::HORIZ_RADIUS + 1);
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;
	localparam int N_RESET      = WIDTH_RESET * HEIGHT_RESET;
	localparam int LAG_RESET    = ctw_pkg::VERT_RADIUS * WIDTH_RESET + ctw_pkg::HORIZ_RADIUS;
	// one line store entry: the eight rows above, newest in the low byte
	localparam int LINE_W = (ctw_pkg::WIN_ROWS - 1) * ctw_pkg::PIX_W;

	typedef logic [ctw_pkg::WIN_ROWS-2:0][ctw_pkg::PIX_W-1:0] entry_t;
	typedef logic [ctw_pkg::WIN_ROWS-1:0][ctw_pkg::PIX_W-1:0] column_t;

	// configuration, stored already clamped to the legal size range
	logic [ctw_pkg::SIZE_W-1:0] width_q, height_q;
	logic [ctw_pkg::SIZE_W-1:0] cfg_clamp_w, cfg_clamp_h;
	logic [CNT_W-1:0]           n_q;
	logic [LAG_W-1:0]           lag_q;
	logic [ctw_pkg::COL_W-1:0]  wm1;
	logic [ctw_pkg::ROW_W-1:0]  hm1;
	logic                       cfg_write;

	// frame counters
	logic [CNT_W-1:0]          t_q;
	logic [ctw_pkg::COL_W-1:0] in_col_q;
	logic [ctw_pkg::ROW_W-1:0] ctr_row_q;
	logic [ctw_pkg::COL_W-1:0] ctr_col_q;

	logic               acc, active, emit, last, adv;
	ctw_pkg::ctr_info_t info;

	// stage 1: line store read in flight
	logic                      v_s1;
	logic [ctw_pkg::PIX_W-1:0] pix_s1;
	logic [ctw_pkg::COL_W-1:0] col_s1;
	ctw_pkg::ctr_info_t        info_s1;
	entry_t                    rd_s1;
	entry_t                    fwdd_s1;
	logic                      fwd_s1;
	entry_t                    entry;
	entry_t                    wentry;
	column_t                   colv;

	logic [LINE_W-1:0] line_store_q [ctw_pkg::MAX_WIDTH];

	// stage 2: window holding the last seven columns
	logic               v_s2;
	ctw_pkg::ctr_info_t info_s2;
	ctw_pkg::win_t      win_q;

	// packing pipeline results
	logic                       pk_valid;
	logic [ctw_pkg::WORD_W-1:0] pk_word;
	logic                       pk_last;
	logic                       push, pop;

	// two-word output buffer
	logic                       ov_q, sv_q;
	logic [ctw_pkg::WORD_W-1:0] oword_q, sword_q;
	logic                       olast_q, slast_q;

	// ---------------------------------------------------------------- config
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready
		&& (cfg_index == ctw_pkg::REG_IMAGE_WIDTH || cfg_index == ctw_pkg::REG_IMAGE_HEIGHT);

	always_comb begin
		if (cfg_data == '0) begin
			cfg_clamp_w = ctw_pkg::SIZE_W'(1);
		end else if (cfg_data > ctw_pkg::SIZE_W'(ctw_pkg::MAX_WIDTH)) begin
			cfg_clamp_w = ctw_pkg::SIZE_W'(ctw_pkg::MAX_WIDTH);
		end else begin
			cfg_clamp_w = cfg_data;
		end
		if (cfg_data == '0) begin
			cfg_clamp_h = ctw_pkg::SIZE_W'(1);
		end else if (cfg_data > ctw_pkg::SIZE_W'(ctw_pkg::HEIGHT_LIMIT)) begin
			cfg_clamp_h = ctw_pkg::SIZE_W'(ctw_pkg::HEIGHT_LIMIT);
		end else begin
			cfg_clamp_h = cfg_data;
		end
	end

	assign wm1 = ctw_pkg::COL_W'(width_q - ctw_pkg::SIZE_W'(1));
	assign hm1 = ctw_pkg::ROW_W'(height_q - ctw_pkg::SIZE_W'(1));

	// ---------------------------------------------------------------- item control
	assign adv           = !(ov_q && sv_q);
	assign s_axis_tready = adv && !cfg_valid;
	assign acc           = s_axis_tvalid && s_axis_tready;
	// a flush tick before the frame's last pixel does nothing
	assign active        = acc && !(s_axis_tuser && (t_q < n_q));
	assign emit          = t_q >= CNT_W'(lag_q);
	assign last          = emit && (ctr_row_q == hm1) && (ctr_col_q == wm1);

	always_comb begin
		info.emit = emit;
		info.last = last;
		info.row  = ctr_row_q;
		info.col  = ctr_col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= ctw_pkg::SIZE_W'(WIDTH_RESET);
			height_q  <= ctw_pkg::SIZE_W'(HEIGHT_RESET);
			n_q       <= CNT_W'(N_RESET);
			lag_q     <= LAG_W'(LAG_RESET);
			t_q       <= '0;
			in_col_q  <= '0;
			ctr_row_q <= '0;
			ctr_col_q <= '0;
			v_s1      <= 1'b0;
			fwd_s1    <= 1'b0;
			v_s2      <= 1'b0;
		end else begin
			n_q   <= CNT_W'(width_q * height_q);
			lag_q <= LAG_W'(ctw_pkg::VERT_RADIUS * width_q + ctw_pkg::HORIZ_RADIUS);
			if (cfg_write) begin
				if (cfg_index == ctw_pkg::REG_IMAGE_WIDTH) begin
					width_q <= cfg_clamp_w;
				end else begin
					height_q <= cfg_clamp_h;
				end
				t_q       <= '0;
				in_col_q  <= '0;
				ctr_row_q <= '0;
				ctr_col_q <= '0;
			end else if (active) begin
				if (last) begin
					// frame done: next item starts a new frame
					t_q       <= '0;
					in_col_q  <= '0;
					ctr_row_q <= '0;
					ctr_col_q <= '0;
				end else begin
					t_q      <= t_q + CNT_W'(1);
					in_col_q <= (in_col_q == wm1) ? '0 : in_col_q + ctw_pkg::COL_W'(1);
					if (emit) begin
						if (ctr_col_q == wm1) begin
							ctr_col_q <= '0;
							ctr_row_q <= ctr_row_q + ctw_pkg::ROW_W'(1);
						end else begin
							ctr_col_q <= ctr_col_q + ctw_pkg::COL_W'(1);
						end
					end
				end
			end
			if (adv) begin
				v_s1 <= active;
				// same column written and read at one edge: take the written entry
				fwd_s1 <= v_s1 && (col_s1 == in_col_q);
				v_s2 <= v_s1 && info_s1.emit;
			end
		end
	end

	// ---------------------------------------------------------------- line store
	// Each active item, flush ticks too, reads its column and writes it back shifted down a row.
	assign entry = fwd_s1 ? fwdd_s1 : rd_s1;
	assign wentry = {entry[ctw_pkg::WIN_ROWS-3:0], pix_s1};

	always_comb begin
		colv[0] = pix_s1;
		for (int k = 1; k < ctw_pkg::WIN_ROWS; k++) begin
			colv[k] = entry[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			line_store_q[col_s1] <= wentry;
		end
		if (adv) begin
			rd_s1 <= line_store_q[in_col_q];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1  <= s_axis_tdata;
			col_s1  <= in_col_q;
			info_s1 <= info;
			fwdd_s1 <= wentry;
		end
		if (adv && v_s1) begin
			info_s2 <= info_s1;
			for (int j = 0; j < ctw_pkg::WIN_COLS - 1; j++) begin
				win_q[j] <= win_q[j+1];
			end
			// newest column on the right, top row first
			for (int i = 0; i < ctw_pkg::WIN_ROWS; i++) begin
				win_q[ctw_pkg::WIN_COLS-1][i] <= colv[ctw_pkg::WIN_ROWS-1-i];
			end
		end
	end

	// ---------------------------------------------------------------- packing
	ctw_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s2),
		.info      (info_s2),
		.win       (win_q),
		.width     (width_q),
		.height    (height_q),
		.out_valid (pk_valid),
		.out_word  (pk_word),
		.out_last  (pk_last)
	);

	// ---------------------------------------------------------------- output buffer
	assign push = adv && pk_valid;
	assign pop  = ov_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else begin
			if (pop) begin
				if (sv_q) begin
					sv_q <= push;
				end else begin
					ov_q <= push;
				end
			end else if (push) begin
				if (ov_q) begin
					sv_q <= 1'b1;
				end else begin
					ov_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && sv_q) begin
			oword_q <= sword_q;
			olast_q <= slast_q;
			if (push) begin
				sword_q <= pk_word;
				slast_q <= pk_last;
			end
		end else if (push && (!ov_q || pop)) begin
			oword_q <= pk_word;
			olast_q <= pk_last;
		end else if (push) begin
			sword_q <= pk_word;
			slast_q <= pk_last;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = ctw_pkg::TDATA_W'(oword_q);
	assign m_axis_tlast  = olast_q;

	// ---------------------------------------------------------------- checks
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		sv_q |-> ov_q)
		else $error("skid word held without output word");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && sv_q) |-> !s_axis_tready)
		else $error("input taken with output buffer full");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(active && !cfg_write && last) |=> (t_q == '0 && in_col_q == '0
			&& ctr_row_q == '0 && ctr_col_q == '0))
		else $error("counters not cleared after frame's last word");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		t_q < n_q + CNT_W'(lag_q))
		else $error("item counter ran past the frame");

endmodule
